@@ sv/rmn_pkg.sv @@
// rmn_pkg: shared constants, codes and types of the regret-matching node.
// Used by every file of the block; depends on nothing.
`default_nettype none
package rmn_pkg;
   localparam int MAX_ACTIONS = 16;
   localparam int AIDX_W = $clog2(MAX_ACTIONS);
   localparam int CNT_W = $clog2(MAX_ACTIONS + 1);
   localparam int ACC_W = 48;                  // Q32.16 accumulators
   localparam int TOT_W = ACC_W + AIDX_W;      // sum over all actions
   localparam int Q_W = 17;                    // Q1.16 probability
   localparam int NUM_W = TOT_W + Q_W;         // divider dividend
   localparam int PROD_W = Q_W + 32;           // weight * probability
   localparam int INC_W = PROD_W - 15;         // rounded increment
   localparam int PTOT_W = 22;                 // probability total
   localparam logic [PTOT_W-1:0] PTOT_MAX = '1;
   localparam logic [Q_W-1:0] Q_ONE = 17'd65536;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0, OP_APPLY = 3'd1, OP_CHECK = 3'd2, OP_ACCUM = 3'd3,
      OP_CURRENT = 3'd4, OP_AVERAGE = 3'd5, OP_CLEAR = 3'd6, OP_UNUSED = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_INVALID = 2'd1, ST_NUMERIC = 2'd2, ST_SPARE = 2'd3
   } status_type;

   localparam logic CSR_NUM_ACTIONS = 1'b0;
   localparam logic CSR_SUM_TOLERANCE = 1'b1;

   typedef struct packed {
      logic [1:0]     status;
      logic [3:0]     action_out;
      logic [Q_W-1:0] probability_out;
      logic           last_out;
   } rsp_type;
endpackage
`default_nettype wire

@@ sv/rmn_if.sv @@
// Channel interfaces of the regret-matching node: request and response.
// Depends on rmn_pkg for widths.
`default_nettype none
interface rmn_req_if;
   logic                      valid;
   logic                      ready;
   logic [2:0]                operation;
   logic [3:0]                slot_index;
   logic signed [31:0]        regret_value;
   logic signed [31:0]        strategy_delta;
   logic [rmn_pkg::Q_W-1:0]   probability;
   logic [rmn_pkg::Q_W-1:0]   weight;
   logic                      last;
   modport source (output valid, operation, slot_index, regret_value, strategy_delta,
                   probability, weight, last, input ready);
   modport sink (input valid, operation, slot_index, regret_value, strategy_delta,
                 probability, weight, last, output ready);
endinterface

interface rmn_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                status;
   logic [3:0]                action_out;
   logic [rmn_pkg::Q_W-1:0]   probability_out;
   logic                      last_out;
   modport source (output valid, status, action_out, probability_out, last_out,
                   input ready);
   modport sink (input valid, status, action_out, probability_out, last_out,
                 output ready);
endinterface
`default_nettype wire

@@ sv/rmn_divider.sv @@
// rmn_divider: restoring divider, one quotient bit per cycle, Q_W quotient bits.
// Depends on rmn_pkg. Caller guarantees numerator >> Q_W is below denominator.
`default_nettype none
module rmn_divider (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [rmn_pkg::NUM_W-1:0]    numerator,
   input  wire logic [rmn_pkg::TOT_W-1:0]    denominator,
   output logic                              done,
   output logic [rmn_pkg::Q_W-1:0]           quotient
);
   localparam int STEP_W = $clog2(rmn_pkg::Q_W + 1);

   logic [rmn_pkg::TOT_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [rmn_pkg::Q_W-1:0]   low_ff, low_in, q_ff, q_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      busy_ff, busy_in, done_ff, done_in;
   logic [rmn_pkg::TOT_W:0]   trial;

   // one shift-and-subtract step per cycle
   always_comb begin
      rem_in = rem_ff;
      den_in = den_ff;
      low_in = low_ff;
      q_in = q_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, low_ff[rmn_pkg::Q_W-1]};
      if (start) begin
         rem_in = numerator[rmn_pkg::NUM_W-1 -: rmn_pkg::TOT_W];
         low_in = numerator[rmn_pkg::Q_W-1:0];
         den_in = denominator;
         q_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         low_in = {low_ff[rmn_pkg::Q_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = rmn_pkg::TOT_W'(trial - {1'b0, den_ff});
            q_in = {q_ff[rmn_pkg::Q_W-2:0], 1'b1};
         end else begin
            rem_in = trial[rmn_pkg::TOT_W-1:0];
            q_in = {q_ff[rmn_pkg::Q_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(rmn_pkg::Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      q_ff <= q_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign quotient = q_ff;
endmodule
`default_nettype wire

@@ sv/regret_matching_node.sv @@
// regret_matching_node: top level with sequencer, accumulators and list buffers.
// Depends on rmn_pkg, rmn_if and rmn_divider.
//
// Usage: requests arrive on req (valid/ready); each transaction carries one
// operation. Responses leave on rsp through an output register. Add regret,
// clear, an unused code and the last element of a list give one status
// response; non-last list elements give none; current/average give one
// probability per action (or one status response on a bad action count).
// csr_write with csr_index/csr_data sets the action count and sum_tolerance;
// it must be used only while the block is idle; the block does not enforce it.
// Sequence: a non-last element is only stored on accept; add, clear and the
// unused code go from accept to response load. A list end runs a check
// pass and then a commit pass for apply, with a tolerance compare between
// them for accumulate, and the check pass only for check. Current/average
// run a sum pass up to the first divide, then per action: start, 17
// quotient bits plus done in the bit-serial divider, hand-off.
// req.ready is high only while the sequencer is idle. A stalled receiver
// holds the output register and stalls the sequencer at the next result.
// Reset (synchronous) zeroes the accumulators, the list state and the
// registers back to an action count of 2, sum_tolerance 16.
`default_nettype none
module regret_matching_node (
   input  wire logic  clock,
   input  wire logic  reset,
   rmn_req_if.sink    req,
   rmn_rsp_if.source  rsp,
   input  wire logic  csr_write,
   input  wire logic  csr_index,
   input  wire logic [7:0] csr_data
);
   localparam int AW = rmn_pkg::AIDX_W;
   localparam int CW = rmn_pkg::CNT_W;
   localparam int AC = rmn_pkg::ACC_W;
   localparam int NA = rmn_pkg::MAX_ACTIONS;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001, S_CHECK = 9'b000000010, S_TOL = 9'b000000100,
      S_COMMIT = 9'b000001000, S_SUM = 9'b000010000, S_DIVST = 9'b000100000,
      S_DIVWAIT = 9'b001000000, S_EMIT = 9'b010000000, S_RESULT = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [AC-1:0] regret_ff [NA];
   logic [AC-1:0]        strat_ff [NA];
   logic [31:0]          pend_r_ff [NA];
   logic [31:0]          pend_s_ff [NA];

   logic [4:0] n_ff, n_in;
   logic [7:0] tol_ff, tol_in;
   logic [1:0] lerr_ff, lerr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [rmn_pkg::PTOT_W-1:0] ptot_ff, ptot_in, phold_ff, phold_in;
   logic [2:0] op_ff, op_in;
   logic [rmn_pkg::Q_W-1:0] w_ff, w_in;
   logic [1:0] st_ff, st_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [rmn_pkg::TOT_W-1:0] total_ff, total_in;
   logic pv_ff, pv_in;
   logic [AW-1:0] pj_ff, pj_in;
   logic [rmn_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic out_vld_ff, out_vld_in;
   rmn_pkg::rsp_type out_ff, out_in;

   // datapath nets
   logic bad_n, out_free, accept, elem_bad, is_last_emit;
   logic [AW-1:0] idx, ci;
   logic [1:0] eerr, lerr_new;
   logic [CW-1:0] count_new;
   logic [rmn_pkg::PTOT_W:0] psum;
   logic [AC:0] add_sum;
   logic [AC-1:0] val;
   logic [rmn_pkg::INC_W-1:0] inc;
   logic [AC:0] r_sum, s_sum, a_sum;
   logic stage_fail;
   logic div_start, div_done;
   logic [rmn_pkg::NUM_W-1:0] div_num;
   logic [rmn_pkg::TOT_W-1:0] div_den;
   logic [rmn_pkg::Q_W-1:0] div_q;
   logic wr_add, wr_clear, wr_commit;
   logic [rmn_pkg::PTOT_W:0] tol_hi, tol_lo;

   assign bad_n = (n_ff == '0) || (32'(n_ff) > NA);
   assign out_free = !out_vld_ff || rsp.ready;
   assign accept = req.valid && req.ready;
   assign idx = req.slot_index[AW-1:0];
   assign ci = cnt_ff[AW-1:0];
   assign req.ready = (state_ff == S_IDLE);

   // element position and value checks
   assign elem_bad = bad_n || ({1'b0, req.slot_index} != 5'(count_ff))
                     || ({1'b0, req.slot_index} >= n_ff);
   always_comb begin
      eerr = rmn_pkg::ST_OK;
      if (elem_bad)
         eerr = rmn_pkg::ST_INVALID;
      else if (req.operation == rmn_pkg::OP_ACCUM)
         eerr = (req.probability > rmn_pkg::Q_ONE) ? rmn_pkg::ST_INVALID : rmn_pkg::ST_OK;
      else if (req.strategy_delta[31])
         eerr = rmn_pkg::ST_NUMERIC;
   end
   assign lerr_new = (lerr_ff != rmn_pkg::ST_OK) ? lerr_ff : eerr;
   assign count_new = elem_bad ? count_ff : count_ff + 1'b1;
   assign psum = {1'b0, ptot_ff} + (rmn_pkg::PTOT_W + 1)'(req.probability);

   // add regret: signed 49-bit sum, overflow when the top two bits differ
   assign add_sum = {regret_ff[idx][AC-1], regret_ff[idx]}
                    + (AC + 1)'(req.regret_value);

   // value walked by the sum and divide passes
   assign val = (op_ff == rmn_pkg::OP_AVERAGE) ? strat_ff[ci]
              : (regret_ff[ci][AC-1] ? '0 : regret_ff[ci]);

   // second stage of the check/commit pass
   assign inc = rmn_pkg::INC_W'(({1'b0, prod_ff} + (rmn_pkg::PROD_W + 1)'(32768)) >> 16);
   assign r_sum = {regret_ff[pj_ff][AC-1], regret_ff[pj_ff]}
                  + (AC + 1)'($signed(pend_r_ff[pj_ff]));
   assign s_sum = {1'b0, strat_ff[pj_ff]} + (AC + 1)'(pend_s_ff[pj_ff]);
   assign a_sum = {1'b0, strat_ff[pj_ff]} + (AC + 1)'(inc);
   always_comb begin
      if (op_ff == rmn_pkg::OP_ACCUM)
         stage_fail = (a_sum[AC:AC-1] != 2'b00);
      else
         stage_fail = (r_sum[AC] != r_sum[AC-1]) || pend_s_ff[pj_ff][31]
                      || (s_sum[AC:AC-1] != 2'b00);
   end

   assign tol_hi = (rmn_pkg::PTOT_W + 1)'(rmn_pkg::Q_ONE) + (rmn_pkg::PTOT_W + 1)'(tol_ff);
   assign tol_lo = {1'b0, phold_ff} + (rmn_pkg::PTOT_W + 1)'(tol_ff);
   assign is_last_emit = (5'(cnt_ff) + 5'd1 == n_ff);

   // divider operands: uniform share or value over total, rounded half up
   always_comb begin
      if (total_ff == '0) begin
         div_num = rmn_pkg::NUM_W'(rmn_pkg::Q_ONE) + rmn_pkg::NUM_W'(n_ff >> 1);
         div_den = rmn_pkg::TOT_W'(n_ff);
      end else begin
         div_num = (rmn_pkg::NUM_W'(val) << 16) + rmn_pkg::NUM_W'(total_ff >> 1);
         div_den = total_ff;
      end
   end

   rmn_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .numerator(div_num), .denominator(div_den),
      .done(div_done), .quotient(div_q)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      tol_in = tol_ff;
      lerr_in = lerr_ff;
      count_in = count_ff;
      ptot_in = ptot_ff;
      phold_in = phold_ff;
      op_in = op_ff;
      w_in = w_ff;
      st_in = st_ff;
      cnt_in = cnt_ff;
      total_in = total_ff;
      pv_in = 1'b0;
      pj_in = ci;
      prod_in = w_ff * pend_s_ff[ci];
      out_vld_in = out_vld_ff && !rsp.ready;
      out_in = out_ff;
      div_start = 1'b0;
      wr_add = 1'b0;
      wr_clear = 1'b0;
      wr_commit = 1'b0;

      if (csr_write) begin
         if (csr_index == rmn_pkg::CSR_NUM_ACTIONS)
            n_in = csr_data[4:0];
         else
            tol_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req.operation;
               w_in = req.weight;
               cnt_in = '0;
               total_in = '0;
               case (req.operation)
                  rmn_pkg::OP_CLEAR: begin
                     wr_clear = 1'b1;
                     lerr_in = rmn_pkg::ST_OK;
                     count_in = '0;
                     ptot_in = '0;
                     st_in = rmn_pkg::ST_OK;
                     state_in = S_RESULT;
                  end
                  rmn_pkg::OP_UNUSED: begin
                     st_in = rmn_pkg::ST_INVALID;
                     state_in = S_RESULT;
                  end
                  rmn_pkg::OP_ADD: begin
                     state_in = S_RESULT;
                     if (bad_n || ({1'b0, req.slot_index} >= n_ff))
                        st_in = rmn_pkg::ST_INVALID;
                     else if (add_sum[AC] != add_sum[AC-1])
                        st_in = rmn_pkg::ST_NUMERIC;
                     else begin
                        st_in = rmn_pkg::ST_OK;
                        wr_add = 1'b1;
                     end
                  end
                  rmn_pkg::OP_CURRENT, rmn_pkg::OP_AVERAGE: begin
                     if (bad_n) begin
                        st_in = rmn_pkg::ST_INVALID;
                        state_in = S_RESULT;
                     end else
                        state_in = S_SUM;
                  end
                  default: begin
                     // list element: apply, check or accumulate
                     count_in = count_new;
                     lerr_in = lerr_new;
                     if (!elem_bad && req.operation == rmn_pkg::OP_ACCUM
                         && req.probability <= rmn_pkg::Q_ONE)
                        ptot_in = psum[rmn_pkg::PTOT_W] ? rmn_pkg::PTOT_MAX
                                                        : psum[rmn_pkg::PTOT_W-1:0];
                     if (req.last) begin
                        lerr_in = rmn_pkg::ST_OK;
                        count_in = '0;
                        ptot_in = '0;
                        phold_in = ptot_in;
                        if (!elem_bad && req.operation == rmn_pkg::OP_ACCUM
                            && req.probability <= rmn_pkg::Q_ONE)
                           phold_in = psum[rmn_pkg::PTOT_W] ? rmn_pkg::PTOT_MAX
                                                            : psum[rmn_pkg::PTOT_W-1:0];
                        else
                           phold_in = ptot_ff;
                        state_in = S_RESULT;
                        if (bad_n || (5'(count_new) != n_ff))
                           st_in = rmn_pkg::ST_INVALID;
                        else if (req.operation == rmn_pkg::OP_ACCUM
                                 && req.weight > rmn_pkg::Q_ONE)
                           st_in = rmn_pkg::ST_INVALID;
                        else if (lerr_new != rmn_pkg::ST_OK)
                           st_in = lerr_new;
                        else
                           state_in = S_CHECK;
                     end
                  end
               endcase
            end
         end
         S_CHECK, S_COMMIT: begin
            if (5'(cnt_ff) < n_ff) begin
               pv_in = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
            if (pv_ff && state_ff == S_COMMIT)
               wr_commit = 1'b1;
            if (pv_ff && state_ff == S_CHECK && stage_fail) begin
               pv_in = 1'b0;
               st_in = rmn_pkg::ST_NUMERIC;
               state_in = S_RESULT;
            end else if (5'(cnt_ff) == n_ff && !pv_ff) begin
               cnt_in = '0;
               st_in = rmn_pkg::ST_OK;
               if (state_ff == S_COMMIT || op_ff == rmn_pkg::OP_CHECK)
                  state_in = S_RESULT;
               else if (op_ff == rmn_pkg::OP_ACCUM)
                  state_in = S_TOL;
               else
                  state_in = S_COMMIT;
            end
         end
         S_TOL: begin
            if ({1'b0, phold_ff} > tol_hi || tol_lo < (rmn_pkg::PTOT_W + 1)'(rmn_pkg::Q_ONE)) begin
               st_in = rmn_pkg::ST_INVALID;
               state_in = S_RESULT;
            end else
               state_in = S_COMMIT;
         end
         S_SUM: begin
            if (5'(cnt_ff) < n_ff) begin
               total_in = total_ff + rmn_pkg::TOT_W'(val);
               cnt_in = cnt_ff + 1'b1;
            end else begin
               cnt_in = '0;
               state_in = S_DIVST;
            end
         end
         S_DIVST: begin
            div_start = 1'b1;
            state_in = S_DIVWAIT;
         end
         S_DIVWAIT: begin
            if (div_done)
               state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               out_in.status = rmn_pkg::ST_OK;
               out_in.action_out = 4'(cnt_ff);
               out_in.probability_out = div_q;
               out_in.last_out = is_last_emit;
               cnt_in = cnt_ff + 1'b1;
               state_in = is_last_emit ? S_IDLE : S_DIVST;
            end
         end
         S_RESULT: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               out_in.status = st_ff;
               out_in.action_out = '0;
               out_in.probability_out = '0;
               out_in.last_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         n_ff <= 5'd2;
         tol_ff <= 8'd16;
         lerr_ff <= rmn_pkg::ST_OK;
         count_ff <= '0;
         ptot_ff <= '0;
         pv_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff <= n_in;
         tol_ff <= tol_in;
         lerr_ff <= lerr_in;
         count_ff <= count_in;
         ptot_ff <= ptot_in;
         pv_ff <= pv_in;
         out_vld_ff <= out_vld_in;
      end
      phold_ff <= phold_in;
      op_ff <= op_in;
      w_ff <= w_in;
      st_ff <= st_in;
      cnt_ff <= cnt_in;
      total_ff <= total_in;
      pj_ff <= pj_in;
      prod_ff <= prod_in;
      out_ff <= out_in;
   end

   // accumulators: cleared at reset and by the clear operation
   always_ff @(posedge clock) begin
      if (reset || wr_clear) begin
         for (int i = 0; i < NA; i++) begin
            regret_ff[i] <= '0;
            strat_ff[i] <= '0;
         end
      end else if (wr_add) begin
         regret_ff[idx] <= add_sum[AC-1:0];
      end else if (wr_commit) begin
         if (op_ff == rmn_pkg::OP_ACCUM)
            strat_ff[pj_ff] <= a_sum[AC-1:0];
         else begin
            regret_ff[pj_ff] <= r_sum[AC-1:0];
            strat_ff[pj_ff] <= s_sum[AC-1:0];
         end
      end
   end

   // list buffers, written only by accepted, well-placed elements
   always_ff @(posedge clock) begin
      if (accept && !elem_bad && (req.operation == rmn_pkg::OP_APPLY
          || req.operation == rmn_pkg::OP_CHECK || req.operation == rmn_pkg::OP_ACCUM)) begin
         if (req.operation == rmn_pkg::OP_ACCUM) begin
            pend_r_ff[idx] <= '0;
            pend_s_ff[idx] <= 32'(req.probability);
         end else begin
            pend_r_ff[idx] <= req.regret_value;
            pend_s_ff[idx] <= req.strategy_delta;
         end
      end
   end

   assign rsp.valid = out_vld_ff;
   assign rsp.status = out_ff.status;
   assign rsp.action_out = out_ff.action_out;
   assign rsp.probability_out = out_ff.probability_out;
   assign rsp.last_out = out_ff.last_out;
endmodule
`default_nettype wire

@@ sv/rmn_checker.sv @@
// rmn_checker: port-level assertions on the response channel of the node.
// Depends on rmn_pkg; bound to regret_matching_node below.
`default_nettype none
module rmn_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [1:0]                  rsp_status,
   input wire logic [3:0]                  rsp_action_out,
   input wire logic [rmn_pkg::Q_W-1:0]     rsp_probability_out,
   input wire logic                        rsp_last_out
);
   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_probability_out) && $stable(rsp_action_out) && $stable(rsp_last_out))
      else $error("response changed while stalled");

   // an error response carries no probability and closes the run
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != rmn_pkg::ST_OK |-> rsp_probability_out == '0 && rsp_last_out)
      else $error("error response carries data");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != rmn_pkg::ST_SPARE)
      else $error("undefined status code");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_probability_out <= rmn_pkg::Q_ONE)
      else $error("probability above one");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind regret_matching_node rmn_checker u_rmn_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
   .rsp_action_out(rsp.action_out), .rsp_probability_out(rsp.probability_out),
   .rsp_last_out(rsp.last_out)
);
`default_nettype wire
